/* design/assert_macros.svh */
// Assertion macros for the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed");
// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, cond)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* design/nqg_pkg.sv */
// Shared widths and status codes for the N-queens solution generator.
package nqg_pkg;
	localparam int SIZE_W  = 5;
	localparam int COL_W   = 4;
	localparam int COUNT_W = 24;
	localparam int PLACE_W = 64;
	localparam int ROWS_IN_WORD = PLACE_W / COL_W;

	typedef logic [SIZE_W-1:0]  size_t;
	typedef logic [COL_W-1:0]   col_t;
	typedef logic [COUNT_W-1:0] count_t;

	typedef enum logic [1:0] {
		STATUS_SOLUTION  = 2'd0,
		STATUS_EXHAUSTED = 2'd1,
		STATUS_NONE      = 2'd2
	} status_t;
endpackage

/* design/nqg_conflict.sv */
// Shared attack check: one placed queen against the candidate square.
module nqg_conflict (
	input  nqg_pkg::col_t  q,
	input  nqg_pkg::size_t col,
	input  nqg_pkg::size_t row_gap,
	output logic           hit
);
	import nqg_pkg::*;

	size_t q_ext;
	size_t diff;

	// same column, or column distance equals row distance (diagonal)
	always_comb begin
		q_ext = SIZE_W'(q);
		diff  = (q_ext > col) ? (q_ext - col) : (col - q_ext);
		hit   = (q_ext == col) || (diff == row_gap);
	end
endmodule

/* design/n_queens_solution_generator.sv */
// Top level: N-queens backtracking search with a shared attack-check unit.
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  cfg     | cfg_we, cfg_wdata (board_size)                 | in
//  request | in_valid, in_ready, restart                    | in
//  result  | out_valid, out_ready, placement,               | out
//          | solution_number, status                        |
//
// One request at a time; in_ready is high only while the sequencer is idle.
// Each candidate square takes a try step, then a check step for each earlier
// row examined by the shared attack-check unit (first row: try step only);
// each backtrack step passes through try (column run out), then back (fetch of
// the row's column). Total search time depends on the board and the search
// position; an already exhausted search goes from idle straight to emit.
// Reset (arst_n low) clears the search and sets the board size to 8.
// A finished result waits in the output register; the sequencer holds its
// last step until the register is free.
module n_queens_solution_generator #(
	parameter int MAX_BOARD = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  nqg_pkg::size_t               cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         restart,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [nqg_pkg::PLACE_W-1:0]  placement,
	output nqg_pkg::count_t              solution_number,
	output logic [1:0]                   status
);
	import nqg_pkg::*;

	localparam int ROW_W = $clog2(MAX_BOARD + 1);
	localparam int IDX_W = (MAX_BOARD > 1) ? $clog2(MAX_BOARD) : 1;
	localparam size_t MAX_N = SIZE_W'(MAX_BOARD);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BACK,
		ST_TRY,
		ST_CHECK,
		ST_EMIT
	} state_t;

	state_t             state_q;
	size_t              board_size_q;
	size_t              n_q;
	logic [ROW_W-1:0]   row_q;
	logic [ROW_W-1:0]   chk_q;
	size_t              col_q;
	count_t             count_q;
	logic               active_q;
	logic               exhausted_q;
	logic               found_q;
	col_t               qc_q [MAX_BOARD];

	logic               out_valid_q;
	logic [PLACE_W-1:0] placement_q;
	count_t             number_q;
	status_t            status_q;

	size_t              eff_size;
	logic [IDX_W-1:0]   rd_idx;
	col_t               qc_rd;
	logic               hit;
	logic               fresh;
	logic               out_free;
	logic [ROW_W-1:0]   row_inc;
	logic [ROW_W-1:0]   chk_inc;
	logic [PLACE_W-1:0] placement_d;
	count_t             count_inc;
	logic               searching;
	logic               blank_report;

	// board size as used by a new search
	always_comb begin
		if (board_size_q == '0)
			eff_size = SIZE_W'(1);
		else if (board_size_q > MAX_N)
			eff_size = MAX_N;
		else
			eff_size = board_size_q;
	end

	// single read port on the column store: check row or backtrack row
	assign rd_idx    = (state_q == ST_CHECK) ? chk_q[IDX_W-1:0] : row_q[IDX_W-1:0];
	assign qc_rd     = qc_q[rd_idx];
	assign row_inc   = row_q + ROW_W'(1);
	assign chk_inc   = chk_q + ROW_W'(1);
	assign count_inc = count_q + COUNT_W'(1);
	assign fresh     = restart || (!active_q && !exhausted_q);
	assign out_free  = !out_valid_q || out_ready;

	nqg_conflict u_conflict (
		.q       (qc_rd),
		.col     (col_q),
		.row_gap (SIZE_W'(row_q - chk_q)),
		.hit     (hit)
	);

	// pack the placed columns, rows beyond the board read as zero
	genvar gr;
	generate
		for (gr = 0; gr < ROWS_IN_WORD; gr++) begin : g_pack
			if (gr < MAX_BOARD) begin : g_row
				assign placement_d[gr*COL_W +: COL_W] =
					(SIZE_W'(gr) < n_q) ? qc_q[gr] : '0;
			end else begin : g_zero
				assign placement_d[gr*COL_W +: COL_W] = '0;
			end
		end
	endgenerate

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			board_size_q <= SIZE_W'(8);
		else if (cfg_we)
			board_size_q <= cfg_wdata;
	end

	// column store: written when a queen is placed
	always_ff @(posedge clk) begin
		if ((state_q == ST_TRY && col_q < n_q && row_q == '0) ||
		    (state_q == ST_CHECK && !hit && chk_inc == row_q))
			qc_q[row_q[IDX_W-1:0]] <= col_q[COL_W-1:0];
	end

	// search sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			n_q         <= '0;
			row_q       <= '0;
			chk_q       <= '0;
			col_q       <= '0;
			count_q     <= '0;
			active_q    <= 1'b0;
			exhausted_q <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
			placement_q <= '0;
			number_q    <= '0;
			status_q    <= STATUS_SOLUTION;
		end else begin
			// taken result; a result reloaded in the same cycle is set below
			if (out_valid_q && out_ready && state_q != ST_EMIT)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (fresh) begin
							n_q         <= eff_size;
							count_q     <= '0;
							active_q    <= 1'b1;
							exhausted_q <= 1'b0;
							row_q       <= '0;
							col_q       <= '0;
							state_q     <= ST_TRY;
						end else if (active_q) begin
							// resume after the last solution from the bottom row
							row_q   <= ROW_W'(n_q - SIZE_W'(1));
							state_q <= ST_BACK;
						end else begin
							found_q <= 1'b0;
							state_q <= ST_EMIT;
						end
					end
				end
				ST_BACK: begin
					col_q   <= SIZE_W'(qc_rd) + SIZE_W'(1);
					state_q <= ST_TRY;
				end
				ST_TRY: begin
					if (col_q >= n_q) begin
						if (row_q == '0) begin
							active_q    <= 1'b0;
							exhausted_q <= 1'b1;
							found_q     <= 1'b0;
							state_q     <= ST_EMIT;
						end else begin
							row_q   <= row_q - ROW_W'(1);
							state_q <= ST_BACK;
						end
					end else if (row_q == '0) begin
						// first row is always safe
						if (SIZE_W'(row_inc) == n_q) begin
							found_q <= 1'b1;
							state_q <= ST_EMIT;
						end else begin
							row_q   <= row_inc;
							col_q   <= '0;
							state_q <= ST_TRY;
						end
					end else begin
						chk_q   <= '0;
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (hit) begin
						col_q   <= col_q + SIZE_W'(1);
						state_q <= ST_TRY;
					end else if (chk_inc == row_q) begin
						if (SIZE_W'(row_inc) == n_q) begin
							found_q <= 1'b1;
							state_q <= ST_EMIT;
						end else begin
							row_q   <= row_inc;
							col_q   <= '0;
							state_q <= ST_TRY;
						end
					end else begin
						chk_q <= chk_inc;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (found_q) begin
							count_q     <= count_inc;
							placement_q <= placement_d;
							number_q    <= count_inc;
							status_q    <= STATUS_SOLUTION;
						end else begin
							placement_q <= '0;
							number_q    <= '0;
							status_q    <= (count_q != '0) ? STATUS_EXHAUSTED : STATUS_NONE;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready        = (state_q == ST_IDLE);
	assign out_valid       = out_valid_q;
	assign placement       = placement_q;
	assign solution_number = number_q;
	assign status          = status_q;

	// terms used by the checks below
	assign searching    = (state_q == ST_BACK) || (state_q == ST_TRY) || (state_q == ST_CHECK);
	assign blank_report = (placement_q == '0) && (number_q == '0);

	`include "assert_macros.svh"

	`ASSERT_ALWAYS(a_active_excl, clk, arst_n, !(active_q && exhausted_q))
	`ASSERT_IMPLIES(a_search_active, clk, arst_n, searching, active_q)
	`ASSERT_IMPLIES(a_chk_below_row, clk, arst_n, state_q == ST_CHECK, chk_q < row_q)
	`ASSERT_IMPLIES(a_size_range, clk, arst_n, active_q, (n_q != '0) && (n_q <= MAX_N))
	`ASSERT_IMPLIES(a_empty_report, clk, arst_n, out_valid_q && (status_q != STATUS_SOLUTION), blank_report)
endmodule

/* tb/sv/tb_n_queens_solution_generator.sv */
// Self-checking testbench for the N-queens solution generator.
`timescale 1ns / 1ps

module tb_n_queens_solution_generator;
	import nqg_pkg::*;

	localparam int BOARD_LIMIT  = 16;
	localparam int RANDOM_ITEMS = 400;
	localparam int HOLD_CYCLES  = 800;

	typedef struct {
		logic [PLACE_W-1:0] placement;
		count_t             number;
		status_t            st;
	} answer_t;

	typedef enum bit {ROW_WRITE, ROW_REQUEST} row_kind_t;

	typedef struct {
		row_kind_t kind;
		size_t     value;
		logic      rs;
		bit        typed;
		answer_t   want;
	} plan_row_t;

	// Block ports
	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_we;
	size_t              cfg_wdata;
	logic               in_valid;
	logic               in_ready;
	logic               restart;
	logic               out_valid;
	logic               out_ready;
	logic [PLACE_W-1:0] placement;
	count_t             solution_number;
	logic [1:0]         status;

	// Answers still owed by the block, oldest first
	answer_t     pending_answers[$];
	plan_row_t   plan[$];
	answer_t     blank;
	int unsigned mismatches = 0;
	bit          steady = 1'b0;
	int unsigned long_hold = 0;
	longint unsigned idle_cycles = 0;
	longint unsigned idle_limit = 20000;

	// Shadow search state
	size_t           board_reg = 5'd8;
	int unsigned     col_of_row[16];
	int unsigned     rows_placed = 0;
	int unsigned     live_size = 0;
	count_t          solutions_seen = '0;
	bit              search_live = 1'b0;
	bit              search_done = 1'b0;
	longint unsigned work_units = 0;

	n_queens_solution_generator #(
		.MAX_BOARD(BOARD_LIMIT)
	) u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.restart         (restart),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.placement       (placement),
		.solution_number (solution_number),
		.status          (status)
	);

	always #5 clk = ~clk;

	// No queen in an earlier row shares the column or a diagonal
	function automatic bit square_clear(int unsigned row, int unsigned col);
		int unsigned q;
		int unsigned dc;
		for (int unsigned r = 0; r < row; r++) begin
			q = col_of_row[r];
			dc = (q > col) ? q - col : col - q;
			if (q == col || dc == row - r)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	// Backtrack from the last solution (or from scratch) to the next one
	function automatic bit find_next_board();
		int unsigned n;
		int unsigned row;
		int unsigned col;
		n = live_size;
		if (rows_placed >= n && n > 0) begin
			row = n - 1;
			col = col_of_row[row] + 1;
		end else begin
			row = 0;
			col = 0;
		end
		while (1'b1) begin
			if (col >= n) begin
				if (row == 0)
					return 1'b0;
				row--;
				col = col_of_row[row] + 1;
				work_units++;
			end else if (square_clear(row, col)) begin
				work_units += row + 1;
				col_of_row[row] = col;
				row++;
				if (row == n) begin
					rows_placed = n;
					return 1'b1;
				end
				col = 0;
			end else begin
				work_units += row + 1;
				col++;
			end
		end
		return 1'b0;
	endfunction

	// Answer owed for one request, updating the shadow search
	function automatic answer_t next_answer(input logic rs);
		answer_t res;
		res.placement = '0;
		res.number    = '0;
		res.st        = STATUS_NONE;
		work_units    = 0;
		if (rs || (!search_live && !search_done)) begin
			if (board_reg == 0)
				live_size = 1;
			else if (board_reg > BOARD_LIMIT)
				live_size = BOARD_LIMIT;
			else
				live_size = board_reg;
			rows_placed    = 0;
			solutions_seen = '0;
			search_live    = 1'b1;
			search_done    = 1'b0;
		end
		if (search_live) begin
			if (find_next_board()) begin
				solutions_seen = solutions_seen + 1'b1;
				for (int unsigned r = 0; r < live_size; r++)
					res.placement |= 64'(col_of_row[r]) << (4 * r);
				res.number = solutions_seen;
				res.st     = STATUS_SOLUTION;
				return res;
			end
			search_live = 1'b0;
			search_done = 1'b1;
			rows_placed = 0;
		end
		res.st = (solutions_seen != 0) ? STATUS_EXHAUSTED : STATUS_NONE;
		return res;
	endfunction

	function automatic void add_row(row_kind_t kind, size_t value, logic rs, bit typed,
			logic [PLACE_W-1:0] pl, count_t num, status_t st);
		plan_row_t row;
		row.kind           = kind;
		row.value          = value;
		row.rs             = rs;
		row.typed          = typed;
		row.want.placement = pl;
		row.want.number    = num;
		row.want.st        = st;
		plan.push_back(row);
	endfunction

	// Present one request and queue its answer once it is taken
	task automatic offer(input logic rs, input bit typed, input answer_t given);
		int unsigned gap;
		bit          took;
		answer_t     res;
		gap = steady ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		restart  <= rs;
		took = 1'b0;
		while (!took) begin
			@(negedge clk);
			took = in_ready;
			@(posedge clk);
		end
		res = next_answer(rs);
		idle_limit = 64'd20000 + 4 * work_units;
		pending_answers.push_back(typed ? given : res);
	endtask

	// Board size changes only once the block has drained
	task automatic write_board_size(input size_t v);
		in_valid <= 1'b0;
		while (pending_answers.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_wdata <= v;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		board_reg = v;
		@(posedge clk);
	endtask

	// Stimulus
	initial begin : stimulus
		int unsigned pick;
		int unsigned size_pick;
		int unsigned burst;
		int unsigned sent_random;
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_wdata <= '0;
		in_valid  <= 1'b0;
		restart   <= 1'b0;
		out_ready <= 1'b0;
		blank.placement = '0;
		blank.number    = '0;
		blank.st        = STATUS_NONE;

		// reset size is 8; a plain request with no search acts as a restart
		add_row(ROW_REQUEST, '0, 1'b0, 1'b1, 64'h31625740, 24'd1, STATUS_SOLUTION);
		add_row(ROW_REQUEST, '0, 1'b0, 1'b0, '0, '0, STATUS_NONE);
		// new size is not taken until the next restart
		add_row(ROW_WRITE, 5'd4, 1'b0, 1'b0, '0, '0, STATUS_NONE);
		add_row(ROW_REQUEST, '0, 1'b0, 1'b0, '0, '0, STATUS_NONE);
		add_row(ROW_REQUEST, '0, 1'b1, 1'b1, 64'h2031, 24'd1, STATUS_SOLUTION);
		add_row(ROW_REQUEST, '0, 1'b0, 1'b1, 64'h1302, 24'd2, STATUS_SOLUTION);
		add_row(ROW_REQUEST, '0, 1'b0, 1'b1, '0, '0, STATUS_EXHAUSTED);
		add_row(ROW_REQUEST, '0, 1'b0, 1'b1, '0, '0, STATUS_EXHAUSTED);
		add_row(ROW_REQUEST, '0, 1'b1, 1'b1, 64'h2031, 24'd1, STATUS_SOLUTION);
		// size 0 behaves as a single square
		add_row(ROW_WRITE, 5'd0, 1'b0, 1'b0, '0, '0, STATUS_NONE);
		add_row(ROW_REQUEST, '0, 1'b0, 1'b1, 64'h1302, 24'd2, STATUS_SOLUTION);
		add_row(ROW_REQUEST, '0, 1'b1, 1'b1, '0, 24'd1, STATUS_SOLUTION);
		add_row(ROW_REQUEST, '0, 1'b0, 1'b1, '0, '0, STATUS_EXHAUSTED);
		// boards with no solution at all
		add_row(ROW_WRITE, 5'd2, 1'b0, 1'b0, '0, '0, STATUS_NONE);
		add_row(ROW_REQUEST, '0, 1'b1, 1'b1, '0, '0, STATUS_NONE);
		add_row(ROW_REQUEST, '0, 1'b0, 1'b1, '0, '0, STATUS_NONE);
		add_row(ROW_WRITE, 5'd3, 1'b0, 1'b0, '0, '0, STATUS_NONE);
		add_row(ROW_REQUEST, '0, 1'b1, 1'b1, '0, '0, STATUS_NONE);
		// oversize saturates to the largest board
		add_row(ROW_WRITE, 5'd31, 1'b0, 1'b0, '0, '0, STATUS_NONE);
		add_row(ROW_REQUEST, '0, 1'b1, 1'b0, '0, '0, STATUS_NONE);
		add_row(ROW_REQUEST, '0, 1'b0, 1'b0, '0, '0, STATUS_NONE);
		add_row(ROW_WRITE, 5'd5, 1'b0, 1'b0, '0, '0, STATUS_NONE);
		add_row(ROW_REQUEST, '0, 1'b1, 1'b0, '0, '0, STATUS_NONE);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_WRITE)
				write_board_size(plan[i].value);
			else
				offer(plan[i].rs, plan[i].typed, plan[i].want);
		end

		// long result stall while requests keep coming
		write_board_size(5'd6);
		long_hold = HOLD_CYCLES;
		steady = 1'b1;
		offer(1'b1, 1'b0, blank);
		repeat (7) offer(1'b0, 1'b0, blank);
		steady = 1'b0;

		// random phases, mostly small boards
		sent_random = 0;
		while (sent_random < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 5)
				size_pick = 0;
			else if (pick < 15)
				size_pick = $urandom_range(1, 3);
			else if (pick < 85)
				size_pick = $urandom_range(4, 8);
			else
				size_pick = $urandom_range(9, 10);
			if ($urandom_range(0, 4) != 0)
				write_board_size(size_t'(size_pick));
			steady = ($urandom_range(0, 3) == 0);
			burst = $urandom_range(5, 40);
			offer($urandom_range(0, 1) == 1, 1'b0, blank);
			sent_random++;
			repeat (burst) begin
				offer($urandom_range(0, 19) == 0, 1'b0, blank);
				sent_random++;
			end
		end

		in_valid <= 1'b0;
		while (pending_answers.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Result side: random stalls, one long hold, field checks
	initial begin : result_side
		answer_t            want;
		logic [PLACE_W-1:0] got_pl;
		count_t             got_num;
		logic [1:0]         got_st;
		bit                 took;
		int unsigned        pause;
		pause = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			took    = out_valid && out_ready;
			got_pl  = placement;
			got_num = solution_number;
			got_st  = status;
			@(posedge clk);
			if (took) begin
				if (pending_answers.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result placement %h number %0d status %0d",
						$time, got_pl, got_num, got_st);
				end else begin
					want = pending_answers.pop_front();
					if (got_pl !== want.placement) begin
						mismatches++;
						$display("%0t: placement expected %h got %h",
							$time, want.placement, got_pl);
					end
					if (got_num !== want.number) begin
						mismatches++;
						$display("%0t: solution_number expected %0d got %0d",
							$time, want.number, got_num);
					end
					if (got_st !== want.st) begin
						mismatches++;
						$display("%0t: status expected %0d got %0d", $time, want.st, got_st);
					end
				end
				pause = steady ? 0 : $urandom_range(0, 3);
			end
			if (long_hold != 0) begin
				long_hold--;
				out_ready <= 1'b0;
			end else if (pause != 0) begin
				pause--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog on cycles with no handshake
	always @(negedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
				idle_cycles = 0;
			else if (idle_cycles >= idle_limit) begin
				$display("Regression FAIL");
				$finish;
			end else
				idle_cycles = idle_cycles + 1;
		end
	end

endmodule

/* filelist.f */
+incdir+design
design/nqg_pkg.sv
design/nqg_conflict.sv
design/n_queens_solution_generator.sv
tb/sv/tb_n_queens_solution_generator.sv
